/* rtl/sstt_pkg.sv */
`default_nettype none

package sstt_pkg;

   // command codes
   localparam logic [1:0] CMD_PRESENT = 2'd0;
   localparam logic [1:0] CMD_SCAN    = 2'd1;
   localparam logic [1:0] CMD_TAKE    = 2'd2;

   // result event codes
   localparam logic [1:0] EV_READY  = 2'd0;
   localparam logic [1:0] EV_TAKEN  = 2'd1;
   localparam logic [1:0] EV_ABSENT = 2'd2;

   // register indexes
   localparam logic REG_TIMEOUT = 1'b0;
   localparam logic REG_MIN     = 1'b1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd30;
   localparam logic [15:0] MIN_RESET     = 16'd30;

   // most ready results one scan may report
   localparam int          CNT_W       = 5;
   localparam logic [4:0]  MAX_RESULTS = 5'd16;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  source_id;
      logic [31:0] frame_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [3:0]  session_id;
      logic [15:0] session_frames;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRES_RD,
      ST_PRES_WR,
      ST_TAKE_RD,
      ST_TAKE_OUT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SCAN_END
   } state_type;

   typedef struct packed {
      logic latch;          // capture the request
      logic scan_clear;     // restart pointer, count and pending result
      logic use_scan_addr;  // table read at the scan pointer
      logic pres_write;     // update the entry for present
      logic take_out;       // close the entry and report for take
      logic scan_check;     // judge the entry at the scan pointer
      logic scan_advance;   // step the scan pointer
      logic scan_end;       // flush the pending ready result
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;      // scan pointer at the final slot
   } ctrl_status_type;

endpackage

`default_nettype wire

/* rtl/sstt_csr.sv */
`default_nettype none

module sstt_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output logic [15:0]      timeout_frames,
   output logic [15:0]      min_frames
);
   import sstt_pkg::*;

   logic [15:0] timeout_ff, timeout_in;
   logic [15:0] min_ff, min_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      timeout_in = timeout_ff;
      min_in     = min_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_TIMEOUT: timeout_in = pwdata[15:0];
            REG_MIN:     min_in     = pwdata[15:0];
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         min_ff     <= MIN_RESET;
      end else begin
         timeout_ff <= timeout_in;
         min_ff     <= min_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_TIMEOUT: prdata = {16'd0, timeout_ff};
         REG_MIN:     prdata = {16'd0, min_ff};
         default:     prdata = 32'd0;
      endcase
   end

   // paddr[1:0] select bytes within a word and are not decoded
   logic unused_addr;
   assign unused_addr = ^paddr[1:0];

   assign timeout_frames = timeout_ff;
   assign min_frames     = min_ff;

endmodule

`default_nettype wire

/* rtl/sstt_ctrl.sv */
`default_nettype none

module sstt_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [1:0]                req_command,
   input  wire sstt_pkg::ctrl_status_type status,
   output sstt_pkg::ctrl_cmd_type         cmd,
   output logic                           busy
);
   import sstt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_command)
                  CMD_PRESENT: state_in = ST_PRES_RD;
                  CMD_SCAN:    state_in = ST_SCAN_RD;
                  CMD_TAKE:    state_in = ST_TAKE_RD;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_PRES_RD:  state_in = ST_PRES_WR;
         ST_PRES_WR:  state_in = ST_IDLE;
         ST_TAKE_RD:  state_in = ST_TAKE_OUT;
         ST_TAKE_OUT: state_in = ST_IDLE;
         ST_SCAN_RD:  state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: state_in = status.scan_last ? ST_SCAN_END : ST_SCAN_RD;
         ST_SCAN_END: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy           = 1'b0;
            cmd.latch      = start;
            cmd.scan_clear = start && (req_command == CMD_SCAN);
         end
         ST_PRES_WR:  cmd.pres_write = 1'b1;
         ST_TAKE_OUT: cmd.take_out   = 1'b1;
         ST_SCAN_RD:  cmd.use_scan_addr = 1'b1;
         ST_SCAN_CHK: begin
            cmd.scan_check   = 1'b1;
            cmd.scan_advance = !status.scan_last;
         end
         ST_SCAN_END: cmd.scan_end = 1'b1;
         default:     ;
      endcase
   end

endmodule

`default_nettype wire

/* rtl/sstt_datapath.sv */
`default_nettype none

module sstt_datapath #(
   parameter int NUM_SOURCES = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sstt_pkg::req_type      req_item,
   input  wire sstt_pkg::ctrl_cmd_type cmd,
   input  wire logic [15:0]            timeout_frames,
   input  wire logic [15:0]            min_frames,
   output sstt_pkg::ctrl_status_type   status,
   output logic                        rsp_valid,
   output sstt_pkg::rsp_type           rsp_item
);
   import sstt_pkg::*;

   localparam int IDX_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam int EXT_W  = (IDX_W > 4) ? IDX_W : 4;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NUM_SOURCES - 1);
   localparam logic [8:0]       NUM_SLOTS = 9'(NUM_SOURCES);

   // request held for the whole command
   req_type req_ff;

   // per-slot flags in flip-flops, session data in a small memory
   logic [NUM_SOURCES-1:0] valid_ff, valid_in;
   logic [NUM_SOURCES-1:0] queued_ff, queued_in;
   logic [31:0]            ls_mem [NUM_SOURCES];
   logic [15:0]            ft_mem [NUM_SOURCES];
   logic [31:0]            ls_rd_ff;
   logic [15:0]            ft_rd_ff;

   logic [IDX_W-1:0] scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [3:0]       pend_id_ff, pend_id_in;
   logic [15:0]      pend_frames_ff, pend_frames_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [EXT_W-1:0] sid_ext, ptr_ext;
   logic [IDX_W-1:0] req_slot, rd_addr;
   logic             in_range, req_valid;
   logic [15:0]      ft_new;
   logic [32:0]      limit;
   logic             expired, longer, hit, drop;

   assign sid_ext   = EXT_W'(req_ff.source_id);
   assign req_slot  = sid_ext[IDX_W-1:0];
   assign in_range  = {5'd0, req_ff.source_id} < NUM_SLOTS;
   assign req_valid = in_range && valid_ff[req_slot];
   assign ptr_ext   = EXT_W'(scan_ptr_ff);
   assign rd_addr   = cmd.use_scan_addr ? scan_ptr_ff : req_slot;

   // saturating frame count, restarting at one for a new session
   assign ft_new = !req_valid          ? 16'd1 :
                   (ft_rd_ff == 16'hFFFF) ? ft_rd_ff : ft_rd_ff + 16'd1;

   // idle test without wrap
   assign limit   = 33'(ls_rd_ff) + 33'(timeout_frames);
   assign expired = valid_ff[scan_ptr_ff] && ({1'b0, req_ff.frame_index} > limit);
   assign longer  = ft_rd_ff > min_frames;
   assign hit     = cmd.scan_check && expired && longer && !queued_ff[scan_ptr_ff]
                    && (cnt_ff < MAX_RESULTS);
   assign drop    = cmd.scan_check && expired && !longer;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pres_write && in_range) begin
         ls_mem[req_slot] <= req_ff.frame_index;
         ft_mem[req_slot] <= ft_new;
      end
      ls_rd_ff <= ls_mem[rd_addr];
      ft_rd_ff <= ft_mem[rd_addr];
   end

   always_comb begin
      valid_in  = valid_ff;
      queued_in = queued_ff;
      if (cmd.pres_write && in_range) begin
         valid_in[req_slot] = 1'b1;
         if (!valid_ff[req_slot]) begin
            queued_in[req_slot] = 1'b0;
         end
      end
      if (cmd.take_out && req_valid) begin
         valid_in[req_slot]  = 1'b0;
         queued_in[req_slot] = 1'b0;
      end
      if (hit) begin
         queued_in[scan_ptr_ff] = 1'b1;
      end
      if (drop) begin
         valid_in[scan_ptr_ff]  = 1'b0;
         queued_in[scan_ptr_ff] = 1'b0;
      end
   end

   // a ready result waits in the pending slot until the next one, or the
   // end of the scan, shows whether it closes the run
   always_comb begin
      scan_ptr_in    = scan_ptr_ff;
      cnt_in         = cnt_ff;
      pend_valid_in  = pend_valid_ff;
      pend_id_in     = pend_id_ff;
      pend_frames_in = pend_frames_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      if (cmd.scan_clear) begin
         scan_ptr_in   = '0;
         cnt_in        = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.scan_advance) begin
         scan_ptr_in = scan_ptr_ff + 1'b1;
      end
      if (hit) begin
         if (pend_valid_ff) begin
            rsp_valid_in          = 1'b1;
            rsp_in.event_res      = EV_READY;
            rsp_in.session_id     = pend_id_ff;
            rsp_in.session_frames = pend_frames_ff;
            rsp_in.last_of_run    = 1'b0;
         end
         pend_valid_in  = 1'b1;
         pend_id_in     = ptr_ext[3:0];
         pend_frames_in = ft_rd_ff;
         cnt_in         = cnt_ff + 1'b1;
      end
      if (cmd.scan_end && pend_valid_ff) begin
         rsp_valid_in          = 1'b1;
         rsp_in.event_res      = EV_READY;
         rsp_in.session_id     = pend_id_ff;
         rsp_in.session_frames = pend_frames_ff;
         rsp_in.last_of_run    = 1'b1;
         pend_valid_in         = 1'b0;
      end
      if (cmd.take_out) begin
         rsp_valid_in          = 1'b1;
         rsp_in.event_res      = req_valid ? EV_TAKEN : EV_ABSENT;
         rsp_in.session_id     = req_ff.source_id;
         rsp_in.session_frames = req_valid ? ft_rd_ff : 16'd0;
         rsp_in.last_of_run    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         queued_ff     <= '0;
         scan_ptr_ff   <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         queued_ff     <= queued_in;
         scan_ptr_ff   <= scan_ptr_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_id_ff     <= pend_id_in;
      pend_frames_ff <= pend_frames_in;
      rsp_ff         <= rsp_in;
   end

   assign status.scan_last = (scan_ptr_ff == LAST_SLOT);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_item         = rsp_ff;

endmodule

`default_nettype wire

/* rtl/source_session_timeout_tracker.sv */
`default_nettype none

// per-source session tracker
// command channel: a transfer on req_item is taken at a clock edge with start
// high and busy low; busy stays high until the command has finished
//   present: opens the slot's session if needed, counts one frame
//     (saturating) and records frame_index as last seen; no result
//   take: closes the slot and returns one result, taken or absent,
//     whose rsp_valid strobe comes after take_rd and take_out, via the result register
//   scan: visits every slot in ascending order, with states scan_rd and
//     scan_chk per slot for the registered read of the session memory; each
//     newly ended session above min_frames gives a ready result, at most 16
//   any other command is dropped and the block stays idle
// result channel: each result is on rsp_item for exactly one cycle with
// rsp_valid high; last_of_run marks the final result of a command; the
// receiver has no back-pressure, the final strobe may overlap the next accept
// reset (synchronous, active high) closes every session and loads both
// registers with 30; session data needs no clearing pass
// registers (APB): timeout_frames at 0x0, min_frames at 0x4, written only idle by the user, unenforced

module source_session_timeout_tracker #(
   parameter int NUM_SOURCES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // command channel
   input  wire logic              start,
   output logic                   busy,
   input  wire sstt_pkg::req_type req_item,
   // result channel
   output logic                   rsp_valid,
   output sstt_pkg::rsp_type      rsp_item,
   // register port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import sstt_pkg::*;

   ctrl_cmd_type    ctrl_cmd;
   ctrl_status_type ctrl_status;
   logic [15:0]     timeout_frames;
   logic [15:0]     min_frames;

   // configuration registers
   sstt_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .timeout_frames (timeout_frames),
      .min_frames     (min_frames)
   );

   // sequencer for the three commands
   sstt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_item.command),
      .status      (ctrl_status),
      .cmd         (ctrl_cmd),
      .busy        (busy)
   );

   // session table, scan datapath and result register
   sstt_datapath #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_item       (req_item),
      .cmd            (ctrl_cmd),
      .timeout_frames (timeout_frames),
      .min_frames     (min_frames),
      .status         (ctrl_status),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item)
   );

   // a result only follows work on a command in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a command in progress");

   // a take answers after its transfer, through take_rd, take_out and the result register, closing the run
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.command == CMD_TAKE))
         |-> ##3 (rsp_valid && rsp_item.last_of_run))
      else $error("take did not produce its single result");

   // a present gives no result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.command == CMD_PRESENT)) |-> ##3 !rsp_valid)
      else $error("present produced a result");

   // only scan results may be followed by more of the same run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.event_res != EV_READY)) |-> rsp_item.last_of_run)
      else $error("take result not marked last of run");

endmodule

`default_nettype wire
